// ----- hw/rtl/mlpf_pkg.sv -----
// Shared constants, types and sigmoid table builder for the MLP forward evaluator.
package mlpf_pkg;

   localparam int MAX_NEURONS       = 16;
   localparam int MAX_HIDDEN_LAYERS = 4;
   localparam int WEIGHT_DEPTH      = 2048;
   localparam int SIG_DEPTH         = 256;

   localparam int WAW      = $clog2(WEIGHT_DEPTH);
   localparam int ABUF_DEPTH = 2 * MAX_NEURONS;
   localparam int ABUF_AW  = $clog2(ABUF_DEPTH);
   // wide enough to hold MAX_NEURONS + 1
   localparam int CNT_W    = $clog2(MAX_NEURONS + 2);
   localparam int LAYER_W  = (MAX_HIDDEN_LAYERS > 0) ? $clog2(MAX_HIDDEN_LAYERS + 1) : 1;
   localparam int OUT_CAP  = (MAX_NEURONS < 16) ? MAX_NEURONS : 16;
   localparam int SIG_AW   = $clog2(SIG_DEPTH);
   localparam int QDEPTH   = 2;
   localparam int QAW      = $clog2(QDEPTH);

   typedef enum logic [2:0] {
      REG_BIAS_VALUE       = 3'd0,
      REG_INVERSE_RESPONSE = 3'd1,
      REG_HIDDEN_LAYERS    = 3'd2,
      REG_HIDDEN_NEURONS   = 3'd3,
      REG_INPUTS           = 3'd4,
      REG_OUTPUTS          = 3'd5
   } reg_index_type;

   typedef enum logic {
      OP_WEIGHT = 1'b0,
      OP_INPUT  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      KIND_WEIGHT = 2'd0,
      KIND_INPUT  = 2'd1,
      KIND_LAST   = 2'd2
   } item_kind_type;

   typedef struct packed {
      item_kind_type      kind;
      logic [10:0]        weight_index;
      logic signed [15:0] weight_value;
      logic signed [15:0] input_value;
   } item_type;

   typedef struct packed {
      logic signed [15:0] bias_value;
      logic [15:0]        inverse_response;
      logic [2:0]         hidden_layers;
      logic [4:0]         hidden_neurons;
      logic [4:0]         inputs;
      logic [4:0]         outputs;
   } cfg_type;

   typedef logic [16:0] sig_tab_type [0:SIG_DEPTH];

   // one table point: 1 / (1 + exp(-z)) in Q0.16, z in Q4.12
   function automatic logic [16:0] sig_point(input longint z);
      longint unsigned t, s, s2, s3, e, d, r, q;
      int i;
      int b;
      t = (z < 0) ? longint'(-z) : longint'(z);
      s = t << 12;
      s2 = (s * s) >> 32;
      s3 = (s2 * s) >> 32;
      e = (64'd1 << 32) - s + (s2 >> 1) - s3 / 6;
      if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
      for (i = 0; i < 8; i++) e = (e * e + (64'd1 << 31)) >> 32;
      d = (64'd1 << 32) + e;
      r = (64'd1 << 48) + (d >> 1);
      q = 0;
      for (b = 16; b >= 0; b--) begin
         if (r >= (d << b)) begin
            r = r - (d << b);
            q = q | (64'd1 << b);
         end
      end
      if (z < 0) return 17'(64'd65536 - q);
      return (q > 64'd65535) ? 17'd65535 : 17'(q);
   endfunction

   function automatic sig_tab_type sig_build();
      sig_tab_type tab;
      int i;
      for (i = 0; i <= SIG_DEPTH; i++)
         tab[i] = sig_point(-32768 + (longint'(i) * 65536) / SIG_DEPTH);
      return tab;
   endfunction

endpackage

// ----- hw/rtl/mlpf_front.sv -----
// Front end: classifies request beats and holds them in a short queue.
module mlpf_front import mlpf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic [10:0]        req_weight_index,
   input  logic signed [15:0] req_weight_value,
   input  logic signed [15:0] req_input_value,
   input  logic               req_input_last,
   output logic               q_valid,
   input  logic               q_pop,
   output item_type           q_item
);

   item_type         qmem_ff [QDEPTH];
   logic [QAW-1:0]   wptr_ff, wptr_in;
   logic [QAW-1:0]   rptr_ff, rptr_in;
   logic [QAW:0]     cnt_ff, cnt_in;
   item_type         new_item;
   logic             push;
   logic             pop;

   always_comb begin
      new_item.weight_index = req_weight_index;
      new_item.weight_value = req_weight_value;
      new_item.input_value  = req_input_value;
      if (op_type'(req_operation) == OP_WEIGHT) new_item.kind = KIND_WEIGHT;
      else if (req_input_last)                  new_item.kind = KIND_LAST;
      else                                      new_item.kind = KIND_INPUT;
   end

   assign req_ready = (cnt_ff < (QAW+1)'(QDEPTH));
   assign q_valid   = (cnt_ff != '0);
   assign q_item    = qmem_ff[rptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_pop && q_valid;

   always_comb begin
      wptr_in = push ? QAW'(wptr_ff + 1'b1) : wptr_ff;
      rptr_in = pop ? QAW'(rptr_ff + 1'b1) : rptr_ff;
      cnt_in  = cnt_ff + (QAW+1)'(push) - (QAW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) qmem_ff[wptr_ff] <= new_item;
   end

endmodule

// ----- hw/rtl/mlpf_sigmoid.sv -----
// Activation pipeline: scale by inverse response, round, saturate, interpolated table sigmoid.
module mlpf_sigmoid import mlpf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [39:0] acc,
   input  logic [15:0]        inv,
   output logic               done,
   output logic [15:0]        y
);

   localparam sig_tab_type SIG_TABLE = sig_build();

   logic                v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [40:0]  ph_ff, ph_in;
   logic [31:0]         pl_ff, pl_in;
   logic signed [15:0]  z_ff, z_in;
   logic signed [34:0]  ip_ff, ip_in;
   logic [16:0]         lo_ff, lo_in;
   logic [15:0]         y_ff, y_in;

   logic signed [57:0]  sum;
   logic signed [33:0]  zw;
   logic [15:0]         u;
   logic [16+SIG_AW-1:0] pos;
   logic [SIG_AW-1:0]   idx;
   logic [15:0]         frac;
   logic signed [17:0]  diff;
   logic signed [19:0]  yw;

   // split 40x16 product into two partial products
   always_comb begin
      ph_in = $signed(acc[39:16]) * $signed({1'b0, inv});
      pl_in = acc[15:0] * inv;
   end

   always_comb begin
      sum = $signed({ph_ff[40], ph_ff, 16'b0}) + $signed({26'b0, pl_ff})
            + $signed(58'd8388608);
      zw = sum[57:24];
      if (zw > 34'sd32767)       z_in = 16'sd32767;
      else if (zw < -34'sd32768) z_in = -16'sd32768;
      else                       z_in = zw[15:0];
   end

   always_comb begin
      u    = {~z_ff[15], z_ff[14:0]};
      pos  = (16+SIG_AW)'(u) << SIG_AW;
      idx  = pos[16+SIG_AW-1:16];
      frac = pos[15:0];
      lo_in = SIG_TABLE[idx];
      diff = $signed({1'b0, SIG_TABLE[(SIG_AW+1)'(idx) + 1'b1]}) - $signed({1'b0, lo_in});
      ip_in = diff * $signed({1'b0, frac});
   end

   always_comb begin
      yw = $signed({3'b0, lo_ff}) + 20'(ip_ff >>> 16);
      if (yw < 20'sd0)          y_in = 16'd0;
      else if (yw > 20'sd65535) y_in = 16'hFFFF;
      else                      y_in = yw[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      ph_ff <= ph_in;
      pl_ff <= pl_in;
      z_ff  <= z_in;
      ip_ff <= ip_in;
      lo_ff <= lo_in;
      y_ff  <= y_in;
   end

   assign done = v4_ff;
   assign y    = y_ff;

endmodule

// ----- hw/rtl/mlpf_back.sv -----
// Back end: weight and activation stores, MAC sequencer, result register.
module mlpf_back import mlpf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_valid,
   output logic        q_pop,
   input  item_type    q_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_output_value,
   output logic [3:0]  rsp_output_index,
   output logic        rsp_output_last,
   output logic        rsp_size_error
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ERR   = 6'b000010,
      ST_MAC   = 6'b000100,
      ST_DRAIN = 6'b001000,
      ST_WAIT  = 6'b010000,
      ST_PUT   = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [LAYER_W-1:0]   layer_ff, layer_in;
   logic [CNT_W-1:0]     nrn_ff, nrn_in;
   logic [CNT_W-1:0]     k_ff, k_in;
   logic [WAW-1:0]       waddr_ff, waddr_in;
   logic                 src_ff, src_in;
   logic signed [39:0]   acc_ff;
   logic                 s1_vld_ff, s1_bias_ff, s2_vld_ff;
   logic signed [31:0]   prod_ff;
   logic [15:0]          y_ff, y_in;
   logic                 rsp_valid_ff;
   logic [15:0]          rsp_value_ff;
   logic [3:0]           rsp_index_ff;
   logic                 rsp_last_ff, rsp_err_ff;

   logic signed [15:0]   wmem [WEIGHT_DEPTH];
   logic signed [15:0]   wrd_ff;
   logic signed [15:0]   abuf [ABUF_DEPTH];
   logic signed [15:0]   ard_ff;

   logic [LAYER_W-1:0]   nh;
   logic [CNT_W-1:0]     nn, ni, no, nin, nout, cnt_sat;
   logic                 is_final, rsp_free, adv;
   logic                 wmem_we, abuf_we, issue, acc_clr, sig_start, rsp_load, rsp_err;
   logic [ABUF_AW-1:0]   abuf_wa, abuf_ra;
   logic signed [15:0]   abuf_wd;
   logic [16:0]          y_round;
   logic signed [40:0]   acc_sum;
   logic                 sig_done;
   logic [15:0]          sig_y;

   always_comb begin
      if (8'(cfg.hidden_layers) > 8'(MAX_HIDDEN_LAYERS)) nh = LAYER_W'(MAX_HIDDEN_LAYERS);
      else                                                nh = LAYER_W'(cfg.hidden_layers);
      if (cfg.hidden_neurons == 5'd0)                          nn = CNT_W'(1);
      else if (8'(cfg.hidden_neurons) > 8'(MAX_NEURONS))       nn = CNT_W'(MAX_NEURONS);
      else                                                     nn = CNT_W'(cfg.hidden_neurons);
      if (cfg.inputs == 5'd0)                                  ni = CNT_W'(1);
      else if (8'(cfg.inputs) > 8'(MAX_NEURONS))               ni = CNT_W'(MAX_NEURONS);
      else                                                     ni = CNT_W'(cfg.inputs);
      if (cfg.outputs == 5'd0)                                 no = CNT_W'(1);
      else if (8'(cfg.outputs) > 8'(OUT_CAP))                  no = CNT_W'(OUT_CAP);
      else                                                     no = CNT_W'(cfg.outputs);
   end

   assign is_final = (layer_ff == nh);
   assign nin      = (layer_ff == '0) ? ni : nn;
   assign nout     = is_final ? no : nn;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign cnt_sat  = (cnt_ff < CNT_W'(MAX_NEURONS + 1)) ? CNT_W'(cnt_ff + 1'b1) : cnt_ff;
   assign abuf_ra  = ABUF_AW'(src_ff ? MAX_NEURONS : 0) + ABUF_AW'(k_ff);
   assign y_round  = {1'b0, y_ff} + 17'd8;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      layer_in  = layer_ff;
      nrn_in    = nrn_ff;
      k_in      = k_ff;
      waddr_in  = waddr_ff;
      src_in    = src_ff;
      y_in      = y_ff;
      q_pop     = 1'b0;
      wmem_we   = 1'b0;
      abuf_we   = 1'b0;
      abuf_wa   = '0;
      abuf_wd   = '0;
      issue     = 1'b0;
      acc_clr   = 1'b0;
      sig_start = 1'b0;
      rsp_load  = 1'b0;
      rsp_err   = 1'b0;
      adv       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.kind == KIND_WEIGHT) begin
                  wmem_we = 1'b1;
               end else begin
                  if (cnt_ff < CNT_W'(MAX_NEURONS)) begin
                     abuf_we = 1'b1;
                     abuf_wa = ABUF_AW'(cnt_ff);
                     abuf_wd = q_item.input_value;
                  end
                  cnt_in = cnt_sat;
                  if (q_item.kind == KIND_LAST) begin
                     cnt_in = '0;
                     if (cnt_sat != ni) begin
                        state_in = ST_ERR;
                     end else begin
                        layer_in = '0;
                        nrn_in   = '0;
                        k_in     = '0;
                        waddr_in = '0;
                        src_in   = 1'b0;
                        acc_clr  = 1'b1;
                        state_in = ST_MAC;
                     end
                  end
               end
            end
         end
         ST_ERR: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               rsp_err  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_MAC: begin
            issue    = 1'b1;
            k_in     = CNT_W'(k_ff + 1'b1);
            waddr_in = WAW'(waddr_ff + 1'b1);
            if (k_ff == nin) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff) begin
               sig_start = 1'b1;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (sig_done) begin
               y_in     = sig_y;
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            if (!is_final) begin
               abuf_we = 1'b1;
               abuf_wa = ABUF_AW'(src_ff ? 0 : MAX_NEURONS) + ABUF_AW'(nrn_ff);
               abuf_wd = 16'(y_round[16:4]);
               adv     = 1'b1;
            end else if (rsp_free) begin
               rsp_load = 1'b1;
               adv      = 1'b1;
            end
            if (adv) begin
               k_in    = '0;
               acc_clr = 1'b1;
               if (CNT_W'(nrn_ff + 1'b1) == nout) begin
                  nrn_in = '0;
                  if (is_final) begin
                     state_in = ST_IDLE;
                  end else begin
                     layer_in = LAYER_W'(layer_ff + 1'b1);
                     src_in   = !src_ff;
                     state_in = ST_MAC;
                  end
               end else begin
                  nrn_in   = CNT_W'(nrn_ff + 1'b1);
                  state_in = ST_MAC;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         layer_ff <= '0;
         nrn_ff   <= '0;
         k_ff     <= '0;
         waddr_ff <= '0;
         src_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         layer_ff <= layer_in;
         nrn_ff   <= nrn_in;
         k_ff     <= k_in;
         waddr_ff <= waddr_in;
         src_ff   <= src_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff <= y_in;
   end

   // weight store: written by weight beats, read by the MAC sequencer
   always_ff @(posedge clock) begin
      if (wmem_we) wmem[WAW'(q_item.weight_index)] <= q_item.weight_value;
      if (issue)   wrd_ff <= wmem[waddr_ff];
   end

   always_ff @(posedge clock) begin
      if (abuf_we) abuf[abuf_wa] <= abuf_wd;
      if (issue)   ard_ff <= abuf[abuf_ra];
   end

   // MAC pipe: read, multiply, accumulate with 40-bit saturation
   assign acc_sum = {acc_ff[39], acc_ff} + 41'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         acc_ff    <= '0;
      end else begin
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
         if (acc_clr) begin
            acc_ff <= '0;
         end else if (s2_vld_ff) begin
            if (acc_sum[40] != acc_sum[39])
               acc_ff <= acc_sum[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
            else
               acc_ff <= acc_sum[39:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_bias_ff <= (k_ff == nin);
      prod_ff    <= wrd_ff * (s1_bias_ff ? cfg.bias_value : ard_ff);
   end

   mlpf_sigmoid u_sigmoid (
      .clock (clock),
      .reset (reset),
      .start (sig_start),
      .acc   (acc_ff),
      .inv   (cfg.inverse_response),
      .done  (sig_done),
      .y     (sig_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff <= rsp_err ? 16'd0 : y_ff;
         rsp_index_ff <= rsp_err ? 4'd0 : 4'(nrn_ff);
         rsp_last_ff  <= rsp_err ? 1'b1 : (CNT_W'(nrn_ff + 1'b1) == nout);
         rsp_err_ff   <= rsp_err;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_output_value = rsp_value_ff;
   assign rsp_output_index = rsp_index_ff;
   assign rsp_output_last  = rsp_last_ff;
   assign rsp_size_error   = rsp_err_ff;

endmodule

// ----- hw/rtl/mlp_forward_sigmoid.sv -----
// Top level of the MLP forward evaluator with sigmoid activation.
// req_ beats either write one weight (operation 0) or present one Q4.12
// network input (operation 1); input_last on an input starts an evaluation.
// rsp_ beats carry one Q0.16 sigmoid output per output neuron, in order,
// output_last on the final one. A wrong input count yields one beat with
// size_error set, value and index zero, output_last set.
// csr_ is a plain write port: registers 0..5 are bias_value,
// inverse_response, hidden_layers_in_use, hidden_neurons_in_use,
// inputs_in_use, outputs_in_use; write only while the block is idle.
// A two-entry queue decouples request acceptance from the sequencer.
// Weight and non-last input beats are consumed while the sequencer is idle.
// Neurons share one MAC unit and are evaluated one at a time: each issues
// one MAC per fan-in input plus one for the bias, then passes through drain,
// activation pipeline and write-back. The first result appears once every
// hidden neuron and the first output neuron have been evaluated after the
// last input beat; each later result follows the next output neuron.
// Reset (synchronous, active high) restores register defaults and empties
// the queue; weights are undefined until written.
// If rsp_ready is low, the sequencer holds at the next result and the
// queue fills, then req_ready drops.
module mlp_forward_sigmoid import mlpf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic [10:0]        req_weight_index,
   input  logic signed [15:0] req_weight_value,
   input  logic signed [15:0] req_input_value,
   input  logic               req_input_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_output_value,
   output logic [3:0]         rsp_output_index,
   output logic               rsp_output_last,
   output logic               rsp_size_error,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   cfg_type  cfg_ff;
   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bias_value       <= -16'sd4096;
         cfg_ff.inverse_response <= 16'd4096;
         cfg_ff.hidden_layers    <= 3'd1;
         cfg_ff.hidden_neurons   <= 5'd10;
         cfg_ff.inputs           <= 5'd4;
         cfg_ff.outputs          <= 5'd4;
      end else if (csr_wr_en) begin
         unique case (reg_index_type'(csr_index))
            REG_BIAS_VALUE:       cfg_ff.bias_value       <= csr_wdata;
            REG_INVERSE_RESPONSE: cfg_ff.inverse_response <= csr_wdata;
            REG_HIDDEN_LAYERS:    cfg_ff.hidden_layers    <= csr_wdata[2:0];
            REG_HIDDEN_NEURONS:   cfg_ff.hidden_neurons   <= csr_wdata[4:0];
            REG_INPUTS:           cfg_ff.inputs           <= csr_wdata[4:0];
            REG_OUTPUTS:          cfg_ff.outputs          <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   mlpf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_weight_index (req_weight_index),
      .req_weight_value (req_weight_value),
      .req_input_value  (req_input_value),
      .req_input_last   (req_input_last),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_item           (q_item)
   );

   mlpf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_item           (q_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_output_value (rsp_output_value),
      .rsp_output_index (rsp_output_index),
      .rsp_output_last  (rsp_output_last),
      .rsp_size_error   (rsp_size_error)
   );

endmodule
